>>> rtl/dap_pkg.sv
// ----------------------------------------------------------------------------
// dap_pkg
// Shared constants, parse phase codes and the result word type of the
// address-range section parser.
// ----------------------------------------------------------------------------
package dap_pkg;

  localparam int MAX_ADDR_BYTES = 8;
  localparam int POS_BITS       = 32;

  localparam logic [3:0] PH_LEN32 = 4'd0;
  localparam logic [3:0] PH_LEN64 = 4'd1;
  localparam logic [3:0] PH_VER   = 4'd2;
  localparam logic [3:0] PH_CUOFF = 4'd3;
  localparam logic [3:0] PH_ASIZE = 4'd4;
  localparam logic [3:0] PH_SSIZE = 4'd5;
  localparam logic [3:0] PH_PAD   = 4'd6;
  localparam logic [3:0] PH_LO    = 4'd7;
  localparam logic [3:0] PH_LEN   = 4'd8;
  localparam logic [3:0] PH_SKIP  = 4'd9;

  localparam logic KIND_RANGE = 1'b0;
  localparam logic KIND_STOP  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] range_lo;
    logic [63:0] range_hi;
    logic [63:0] unit_offset;
  } dap_res_t;

endpackage

>>> rtl/dap_result_fifo.sv
// ----------------------------------------------------------------------------
// dap_result_fifo
// Two-word result buffer: an output register and a skid register, so the
// parser keeps taking bytes while a result waits downstream.
// ----------------------------------------------------------------------------
module dap_result_fifo import dap_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dap_res_t res_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dap_res_t res_o
);

  logic     out_v_q, out_v_d;
  logic     skid_v_q, skid_v_d;
  dap_res_t out_q, out_d;
  dap_res_t skid_q, skid_d;
  logic     pop;

  assign pop = out_v_q & ~out_stall_i;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = push_i;
        out_d   = res_i;
      end
    end else if (push_i) begin
      if (!out_v_q) begin
        out_v_d = 1'b1;
        out_d   = res_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

>>> rtl/dwarf_aranges_parser_unit.sv
// ----------------------------------------------------------------------------
// dwarf_aranges_parser_unit
// Byte-serial parser of an address-range debug section: unit headers,
// padding and (start, length) tuples, one range word per tuple with a nonzero length.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                   | payload
//   in      | input     | in_valid_i / in_stall_o     | data_byte_i, first_byte_i
//   out     | output    | out_valid_o / out_stall_i   | kind_o, range_lo_o,
//           |           |                             | range_hi_o, unit_offset_o
//
// While in_stall_o is low one byte is taken per cycle; fields are shifted in a
// byte at a time and the range end is summed one byte per cycle with a carry
// as length bytes arrive. A result leaves through a two-word output buffer.
// in_stall_o rises only while both buffer words are occupied.
// Reset clears the parse state; first_byte_i restarts it without a reset.
// ----------------------------------------------------------------------------
module dwarf_aranges_parser_unit import dap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [63:0] range_lo_o,
  output logic [63:0] range_hi_o,
  output logic [63:0] unit_offset_o
);

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  logic                in_acc;
  logic                full;
  logic                push;
  dap_res_t            res;
  dap_res_t            res_out;

  logic [3:0]          phase_q, phase_d;
  logic [3:0]          cnt_q, cnt_d;
  logic                stop_q, stop_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] uend_q, uend_d;
  logic                off8_q, off8_d;
  logic [3:0]          abytes_q, abytes_d;
  logic [3:0]          mod_q [MAX_ADDR_BYTES];
  logic [3:0]          mod_d [MAX_ADDR_BYTES];

  logic [63:0]         acc_q, acc_d;
  logic [63:0]         start_q, start_d;
  logic [63:0]         sum_q, sum_d;
  logic                carry_q, carry_d;
  logic                lennz_q, lennz_d;
  logic [63:0]         cuoff_q, cuoff_d;
  logic [3:0]          pad_q, pad_d;
  logic                verok_q, verok_d;

  logic [3:0]          ph_e, cnt_e, abytes_e;
  logic                stop_e, off8_e;
  logic [POS_BITS-1:0] pos_e, uend_e, nxt;
  logic [3:0]          mod_e [MAX_ADDR_BYTES];
  logic [3:0]          cnt_n, nm, sh;
  logic [8:0]          sbyte;
  logic [63:0]         sum_n;
  logic [71:0]         hi_w;
  logic [4:0]          pad_w;

  function automatic logic [POS_BITS-1:0] sat_end(logic [POS_BITS-1:0] nx,
                                                 logic [63:0] len);
    logic [POS_BITS:0] s;
    s = {1'b0, nx} + {1'b0, len[POS_BITS-1:0]};
    if ((len >> POS_BITS) != 64'd0 || s[POS_BITS]) begin
      return POS_MAX;
    end
    return s[POS_BITS-1:0];
  endfunction

  assign in_acc     = in_valid_i & ~full;
  assign in_stall_o = full;

  always_comb begin
    ph_e     = first_byte_i ? PH_LEN32 : phase_q;
    cnt_e    = first_byte_i ? 4'd0 : cnt_q;
    stop_e   = first_byte_i ? 1'b0 : stop_q;
    pos_e    = first_byte_i ? '0 : pos_q;
    uend_e   = first_byte_i ? '0 : uend_q;
    off8_e   = first_byte_i ? 1'b0 : off8_q;
    abytes_e = first_byte_i ? 4'd0 : abytes_q;
    for (int j = 0; j < MAX_ADDR_BYTES; j++) begin
      mod_e[j] = first_byte_i ? 4'd0 : mod_q[j];
    end
    nxt   = pos_e + 1'b1;
    acc_d = {data_byte_i, acc_q[63:8]};
    cnt_n = cnt_e + 4'd1;

    phase_d  = phase_q;
    cnt_d    = cnt_q;
    stop_d   = stop_q;
    pos_d    = pos_q;
    uend_d   = uend_q;
    off8_d   = off8_q;
    abytes_d = abytes_q;
    for (int j = 0; j < MAX_ADDR_BYTES; j++) begin
      mod_d[j] = mod_q[j];
    end
    start_d = start_q;
    sum_d   = sum_q;
    carry_d = carry_q;
    lennz_d = lennz_q;
    cuoff_d = cuoff_q;
    pad_d   = pad_q;
    verok_d = verok_q;
    push    = 1'b0;
    res     = '0;

    nm    = mod_e[3'(abytes_e - 4'd1)];
    nm    = (nxt == '0) ? 4'd0 : ((nm == 4'(2 * abytes_e - 4'd1)) ? 4'd0 : nm + 4'd1);
    pad_w = (nm == 4'd0) ? 5'd0 : ({abytes_e, 1'b0} - {1'b0, nm});
    sh    = 4'd8 - abytes_e;
    sbyte = {1'b0, data_byte_i} + {1'b0, start_q[{cnt_e[2:0], 3'b000} +: 8]}
            + {8'd0, carry_q};
    sum_n = {sbyte[7:0], sum_q[63:8]};
    hi_w  = {7'd0, sbyte[8], sum_n} >> {sh, 3'b000};

    if (in_acc) begin
      phase_d  = ph_e;
      cnt_d    = cnt_e;
      stop_d   = stop_e;
      pos_d    = pos_e;
      uend_d   = uend_e;
      off8_d   = off8_e;
      abytes_d = abytes_e;
      for (int j = 0; j < MAX_ADDR_BYTES; j++) begin
        mod_d[j] = mod_e[j];
      end
      if (!stop_e) begin
        pos_d = nxt;
        for (int j = 0; j < MAX_ADDR_BYTES; j++) begin
          mod_d[j] = (nxt == '0 || mod_e[j] == 4'(2 * j + 1)) ? 4'd0 : mod_e[j] + 4'd1;
        end
        case (ph_e)
          PH_LEN32: begin
            cnt_d = cnt_n;
            if (cnt_n == 4'd4) begin
              cnt_d = 4'd0;
              if (acc_d[63:32] == 32'hffff_ffff) begin
                off8_d  = 1'b1;
                phase_d = PH_LEN64;
              end else begin
                off8_d  = 1'b0;
                uend_d  = sat_end(nxt, {32'd0, acc_d[63:32]});
                phase_d = PH_VER;
              end
            end
          end
          PH_LEN64: begin
            cnt_d = cnt_n;
            if (cnt_n == 4'd8) begin
              cnt_d   = 4'd0;
              uend_d  = sat_end(nxt, acc_d);
              phase_d = PH_VER;
            end
          end
          PH_VER: begin
            cnt_d = cnt_n;
            if (cnt_n == 4'd2) begin
              cnt_d   = 4'd0;
              verok_d = (acc_d[63:48] == 16'd2);
              phase_d = PH_CUOFF;
            end
          end
          PH_CUOFF: begin
            cnt_d = cnt_n;
            if (cnt_n == (off8_e ? 4'd8 : 4'd4)) begin
              cnt_d   = 4'd0;
              cuoff_d = off8_e ? acc_d : {32'd0, acc_d[63:32]};
              phase_d = PH_ASIZE;
            end
          end
          PH_ASIZE: begin
            abytes_d = (data_byte_i == 8'd0 || data_byte_i > 8'(MAX_ADDR_BYTES)) ?
                       4'd0 : data_byte_i[3:0];
            phase_d  = PH_SSIZE;
          end
          PH_SSIZE: begin
            if (!verok_q || abytes_e == 4'd0) begin
              stop_d   = 1'b1;
              push     = 1'b1;
              res.kind = KIND_STOP;
            end else begin
              pad_d   = pad_w[3:0];
              cnt_d   = 4'd0;
              phase_d = (pad_w[3:0] != 4'd0) ? PH_PAD : PH_LO;
            end
          end
          PH_PAD: begin
            pad_d = pad_q - 4'd1;
            if (pad_q == 4'd1) begin
              phase_d = PH_LO;
            end
          end
          PH_LO, PH_LEN: begin
            if (pos_e >= uend_e) begin
              stop_d   = 1'b1;
              push     = 1'b1;
              res.kind = KIND_STOP;
            end else if (ph_e == PH_LO) begin
              cnt_d = cnt_n;
              if (cnt_n == abytes_e) begin
                cnt_d   = 4'd0;
                start_d = acc_d >> {sh, 3'b000};
                carry_d = 1'b0;
                lennz_d = 1'b0;
                phase_d = PH_LEN;
              end
            end else begin
              cnt_d   = cnt_n;
              sum_d   = sum_n;
              carry_d = sbyte[8];
              lennz_d = lennz_q | (data_byte_i != 8'd0);
              if (cnt_n == abytes_e) begin
                cnt_d = 4'd0;
                if (start_q == 64'd0 && !lennz_d) begin
                  phase_d = (nxt == uend_e) ? PH_LEN32 : PH_SKIP;
                end else begin
                  phase_d = PH_LO;
                  if (lennz_d) begin
                    push            = 1'b1;
                    res.kind        = KIND_RANGE;
                    res.range_lo    = start_q;
                    res.range_hi    = hi_w[63:0];
                    res.unit_offset = cuoff_q;
                  end
                end
              end
            end
          end
          PH_SKIP: begin
            if (nxt == uend_e) begin
              phase_d = PH_LEN32;
            end
          end
          default: begin
            stop_d   = 1'b1;
            push     = 1'b1;
            res.kind = KIND_STOP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN32;
      cnt_q    <= 4'd0;
      stop_q   <= 1'b0;
      pos_q    <= '0;
      uend_q   <= '0;
      off8_q   <= 1'b0;
      abytes_q <= 4'd0;
      for (int j = 0; j < MAX_ADDR_BYTES; j++) begin
        mod_q[j] <= 4'd0;
      end
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      stop_q   <= stop_d;
      pos_q    <= pos_d;
      uend_q   <= uend_d;
      off8_q   <= off8_d;
      abytes_q <= abytes_d;
      for (int j = 0; j < MAX_ADDR_BYTES; j++) begin
        mod_q[j] <= mod_d[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_q <= acc_d;
    end
    start_q <= start_d;
    sum_q   <= sum_d;
    carry_q <= carry_d;
    lennz_q <= lennz_d;
    cuoff_q <= cuoff_d;
    pad_q   <= pad_d;
    verok_q <= verok_d;
  end

  dap_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign kind_o        = res_out.kind;
  assign range_lo_o    = res_out.range_lo;
  assign range_hi_o    = res_out.range_hi;
  assign unit_offset_o = res_out.unit_offset;

  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result on the output");

  a_quiet_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && stop_q && !first_byte_i) |-> !push)
    else $error("result raised after parsing stopped");

  a_range_from_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.kind == KIND_RANGE) |-> (phase_q == PH_LEN && !first_byte_i))
    else $error("range raised outside the length field");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < 4'd8)
    else $error("field byte count out of range");

endmodule
